// ----- src/gwt_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gwt_pkg
// Shared types, character codes and helper functions of the G-code word
// tokenizer.
// ============================================================================
package gwt_pkg;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_COMMAND    = 3'd1,
        PH_SCAN       = 3'd2,
        PH_SIGN       = 3'd3,
        PH_NUMBER     = 3'd4,
        PH_TAIL       = 3'd5,
        PH_COMMENT    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_LINE_END = 2'd0,
        KIND_COMMAND  = 2'd1,
        KIND_PARAM    = 2'd2
    } word_kind_t;

    localparam logic [7:0]  CH_NEWLINE = 8'd10;
    localparam logic [7:0]  CH_SPACE   = 8'd32;
    localparam logic [7:0]  CH_TAB     = 8'd9;
    localparam logic [7:0]  CH_CR      = 8'd13;
    localparam logic [7:0]  CH_SEMI    = 8'h3B;
    localparam logic [7:0]  CH_MINUS   = 8'h2D;
    localparam logic [7:0]  CH_PLUS    = 8'h2B;
    localparam logic [7:0]  CH_DOT     = 8'h2E;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [7:0]  CH_UP_A    = 8'h41;
    localparam logic [7:0]  CH_UP_Z    = 8'h5A;
    localparam logic [7:0]  CH_LOW_A   = 8'h61;
    localparam logic [7:0]  CH_LOW_Z   = 8'h7A;
    localparam logic [6:0]  CASE_MASK  = 7'h5F;
    localparam logic [15:0] CMD_MAX    = 16'hFFFF;

    // Fraction digit counter width; the digit count never exceeds FRACTION_DIGITS.
    localparam int CNT_W = 3;

    typedef struct packed {
        logic       is_newline;
        logic       is_space;
        logic       is_letter;
        logic       is_digit;
        logic       is_semi;
        logic       is_plus;
        logic       is_minus;
        logic       is_dot;
        logic [3:0] digit;
        logic [6:0] letter;
    } char_class_t;

    typedef struct packed {
        word_kind_t       kind;
        logic [6:0]       letter;
        logic             digit_seen;
        logic             negative;
        logic             overflow;
        logic             line_end;
        logic [CNT_W-1:0] frac_cnt;
    } word_ctl_t;

    typedef struct packed {
        word_kind_t         kind;
        logic [6:0]         letter;
        logic [15:0]        command_number;
        logic               has_digits;
        logic signed [31:0] value_milli;
        logic               saturated;
        logic               line_end;
    } result_t;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic int frac_bits(input int fd);
        return (fd == 0) ? 1 : $clog2(10 ** fd);
    endfunction

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r.is_newline = (c == CH_NEWLINE);
        r.is_space   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        r.is_letter  = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                       ((c >= CH_LOW_A) && (c <= CH_LOW_Z));
        r.is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        r.is_semi    = (c == CH_SEMI);
        r.is_plus    = (c == CH_PLUS);
        r.is_minus   = (c == CH_MINUS);
        r.is_dot     = (c == CH_DOT);
        r.digit      = c[3:0];
        r.letter     = c[6:0] & CASE_MASK;
        return r;
    endfunction

endpackage

// ----- src/gwt_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gwt_front
// Classifies each incoming character and holds it in a short queue until
// the scanner takes it.
// ============================================================================
module gwt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           char_byte,
    output logic                 full,
    output logic                 deq_valid,
    input  logic                 deq_ready,
    output gwt_pkg::char_class_t deq_class
);
    import gwt_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    char_class_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]       count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == LVL_W'(DEPTH));
    assign deq_valid = (count_reg != '0);
    assign deq_class = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = deq_valid && deq_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + LVL_W'(do_push) - LVL_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= classify(char_byte);
        end
    end

endmodule

// ----- src/gwt_scanner.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gwt_scanner
// Per-character state machine that collects letters, signs and digits into
// words and hands each finished word to the formatter.
// ============================================================================
module gwt_scanner #(
    parameter int VALUE_BITS      = 32,
    parameter int FRACTION_DIGITS = 3
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  gwt_pkg::char_class_t                        in_class,
    output logic                                        in_ready,
    output logic                                        rec_valid,
    output gwt_pkg::word_ctl_t                          rec_ctl,
    output logic [VALUE_BITS-1:0]                       rec_acc,
    output logic [gwt_pkg::frac_bits(FRACTION_DIGITS)-1:0] rec_frac,
    input  logic                                        rec_ready
);
    import gwt_pkg::*;

    localparam int ACC_W  = VALUE_BITS;
    localparam int EXT_W  = ACC_W + 4;
    localparam int FRAC_W = frac_bits(FRACTION_DIGITS);
    localparam int FMAC_W = FRAC_W + 4;
    localparam logic [EXT_W-1:0] CAP = EXT_W'(1) << (ACC_W - 1);

    phase_t             phase_reg, phase_next;
    logic [6:0]         letter_reg, letter_next;
    logic               neg_reg, neg_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               digit_reg, digit_next;
    logic               dot_reg, dot_next;
    logic               ovf_reg, ovf_next;

    logic               rec_valid_reg, rec_valid_next;
    word_ctl_t          rec_ctl_reg, rec_ctl_next;
    logic [ACC_W-1:0]   rec_acc_reg;
    logic [FRAC_W-1:0]  rec_frac_reg;

    logic               step;
    logic               num_char;
    logic               word_end;
    logic               emit;
    phase_t             after_scan;
    logic [EXT_W-1:0]   acc_ext;
    logic [EXT_W-1:0]   acc_mac;
    logic [FMAC_W-1:0]  frac_ext;
    logic [FMAC_W-1:0]  frac_mac;

    assign in_ready  = !rec_valid_reg || rec_ready;
    assign step      = in_valid && in_ready;
    assign num_char  = in_class.is_digit || in_class.is_dot;
    assign rec_valid = rec_valid_reg;
    assign rec_ctl   = rec_ctl_reg;
    assign rec_acc   = rec_acc_reg;
    assign rec_frac  = rec_frac_reg;

    assign acc_ext  = EXT_W'(acc_reg);
    assign acc_mac  = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(in_class.digit);
    assign frac_ext = FMAC_W'(frac_reg);
    assign frac_mac = (frac_ext << 3) + (frac_ext << 1) + FMAC_W'(in_class.digit);

    always_comb
    begin
        if (in_class.is_letter)
        begin
            after_scan = PH_SIGN;
        end
        else if (in_class.is_semi)
        begin
            after_scan = PH_COMMENT;
        end
        else
        begin
            after_scan = PH_SCAN;
        end
    end

    // A word ends on any character that cannot continue it.
    always_comb
    begin
        unique case (phase_reg)
            PH_COMMAND: word_end = !in_class.is_digit;
            PH_SIGN:    word_end = !(in_class.is_plus || in_class.is_minus || num_char);
            PH_NUMBER:  word_end = !num_char;
            PH_TAIL:    word_end = !num_char;
            default:    word_end = 1'b0;
        endcase
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (in_class.is_newline)
            begin
                phase_next = PH_LINE_START;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LINE_START:
                    begin
                        if (in_class.is_letter)
                        begin
                            phase_next = PH_COMMAND;
                        end
                        else if (!in_class.is_space)
                        begin
                            phase_next = after_scan;
                        end
                    end
                    PH_COMMAND:
                    begin
                        if (word_end)
                        begin
                            phase_next = after_scan;
                        end
                    end
                    PH_SIGN:
                    begin
                        phase_next = word_end ? after_scan : PH_NUMBER;
                    end
                    PH_NUMBER:
                    begin
                        if (word_end)
                        begin
                            phase_next = after_scan;
                        end
                        else if (in_class.is_dot && dot_reg)
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        if (word_end)
                        begin
                            phase_next = after_scan;
                        end
                    end
                    PH_COMMENT:
                    begin
                        phase_next = PH_COMMENT;
                    end
                    default:
                    begin
                        phase_next = after_scan;
                    end
                endcase
            end
        end
    end

    // Word datapath and the finished-word record.
    always_comb
    begin
        letter_next = letter_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        digit_next  = digit_reg;
        dot_next    = dot_reg;
        ovf_next    = ovf_reg;
        emit        = 1'b0;

        rec_ctl_next.kind       = KIND_LINE_END;
        rec_ctl_next.letter     = letter_reg;
        rec_ctl_next.digit_seen = digit_reg;
        rec_ctl_next.negative   = neg_reg;
        rec_ctl_next.overflow   = ovf_reg;
        rec_ctl_next.line_end   = in_class.is_newline;
        rec_ctl_next.frac_cnt   = cnt_reg;

        if (phase_reg == PH_COMMAND)
        begin
            rec_ctl_next.kind = KIND_COMMAND;
        end
        else if ((phase_reg == PH_NUMBER || phase_reg == PH_TAIL) && digit_reg)
        begin
            rec_ctl_next.kind = KIND_PARAM;
        end
        else
        begin
            rec_ctl_next.letter = 7'd0;
        end

        if (step)
        begin
            if (in_class.is_newline || word_end)
            begin
                emit = in_class.is_newline || (rec_ctl_next.kind != KIND_LINE_END);
                neg_next   = 1'b0;
                acc_next   = '0;
                frac_next  = '0;
                cnt_next   = '0;
                digit_next = 1'b0;
                dot_next   = 1'b0;
                ovf_next   = 1'b0;
                if (in_class.is_newline)
                begin
                    letter_next = 7'd0;
                end
                else if (in_class.is_letter)
                begin
                    letter_next = in_class.letter;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LINE_START, PH_SCAN:
                    begin
                        if (in_class.is_letter)
                        begin
                            letter_next = in_class.letter;
                            neg_next    = 1'b0;
                            acc_next    = '0;
                            frac_next   = '0;
                            cnt_next    = '0;
                            digit_next  = 1'b0;
                            dot_next    = 1'b0;
                            ovf_next    = 1'b0;
                        end
                    end
                    PH_COMMAND:
                    begin
                        digit_next = 1'b1;
                        if (acc_mac > EXT_W'(CMD_MAX))
                        begin
                            acc_next = ACC_W'(CMD_MAX);
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_mac[ACC_W-1:0];
                        end
                    end
                    PH_SIGN, PH_NUMBER:
                    begin
                        if (in_class.is_plus || in_class.is_minus)
                        begin
                            neg_next = in_class.is_minus;
                        end
                        else if (in_class.is_dot)
                        begin
                            if (!dot_reg)
                            begin
                                dot_next = 1'b1;
                            end
                        end
                        else
                        begin
                            digit_next = 1'b1;
                            if (dot_reg)
                            begin
                                if (cnt_reg < CNT_W'(FRACTION_DIGITS))
                                begin
                                    frac_next = frac_mac[FRAC_W-1:0];
                                    cnt_next  = cnt_reg + CNT_W'(1);
                                end
                            end
                            else if (acc_mac > CAP)
                            begin
                                acc_next = CAP[ACC_W-1:0];
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = acc_mac[ACC_W-1:0];
                            end
                        end
                    end
                    default:
                    begin
                        // Tail and comment characters are eaten.
                    end
                endcase
            end
        end

        if (in_ready)
        begin
            rec_valid_next = emit;
        end
        else
        begin
            rec_valid_next = rec_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            letter_reg    <= 7'd0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            digit_reg     <= 1'b0;
            dot_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            letter_reg    <= letter_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            frac_reg      <= frac_next;
            cnt_reg       <= cnt_next;
            digit_reg     <= digit_next;
            dot_reg       <= dot_next;
            ovf_reg       <= ovf_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rec_ctl_reg  <= rec_ctl_next;
            rec_acc_reg  <= acc_reg;
            rec_frac_reg <= frac_reg;
        end
    end

endmodule

// ----- src/gwt_formatter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gwt_formatter
// Scales, clamps and signs finished words and queues the results for the
// consumer.
// ============================================================================
module gwt_formatter #(
    parameter int VALUE_BITS      = 32,
    parameter int FRACTION_DIGITS = 3
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        rec_valid,
    input  gwt_pkg::word_ctl_t                          rec_ctl,
    input  logic [VALUE_BITS-1:0]                       rec_acc,
    input  logic [gwt_pkg::frac_bits(FRACTION_DIGITS)-1:0] rec_frac,
    output logic                                        rec_ready,
    output logic                                        empty,
    input  logic                                        pop,
    output gwt_pkg::result_t                            result
);
    import gwt_pkg::*;

    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int LVL_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = VALUE_BITS + 21;
    localparam int FULL_W = 65;
    localparam logic [WIDE_W-1:0] SCALE     = WIDE_W'(pow10(FRACTION_DIGITS));
    localparam logic [WIDE_W-1:0] LIMIT_POS = (WIDE_W'(1) << (VALUE_BITS - 1)) - WIDE_W'(1);

    result_t                entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]       count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    logic [WIDE_W-1:0]      frac_scaled;
    logic [WIDE_W-1:0]      int_scaled;
    logic [WIDE_W-1:0]      total;
    logic [WIDE_W-1:0]      limit;
    logic                   sat;
    logic [WIDE_W-1:0]      mag;
    logic [FULL_W-1:0]      mag_full;
    logic [FULL_W-1:0]      val_full;
    result_t                res;

    // Short fractions are padded to the full number of decimals.
    always_comb
    begin
        frac_scaled = '0;
        for (int k = 0; k <= FRACTION_DIGITS; k++)
        begin
            if (rec_ctl.frac_cnt == CNT_W'(k))
            begin
                frac_scaled = WIDE_W'(rec_frac) * WIDE_W'(pow10(FRACTION_DIGITS - k));
            end
        end
    end

    // A negative value may reach one count further than a positive one.
    always_comb
    begin
        int_scaled = WIDE_W'(rec_acc) * SCALE;
        total      = int_scaled + frac_scaled;
        limit      = LIMIT_POS + WIDE_W'(rec_ctl.negative);
        sat        = rec_ctl.overflow || (total > limit);
        mag        = sat ? limit : total;
        mag_full   = FULL_W'(mag[VALUE_BITS-1:0]);
        val_full   = rec_ctl.negative ? (~mag_full + FULL_W'(1)) : mag_full;
    end

    always_comb
    begin
        res.kind           = rec_ctl.kind;
        res.letter         = 7'd0;
        res.command_number = 16'd0;
        res.has_digits     = 1'b0;
        res.value_milli    = 32'sd0;
        res.saturated      = 1'b0;
        res.line_end       = rec_ctl.line_end;
        unique case (rec_ctl.kind)
            KIND_COMMAND:
            begin
                res.letter         = rec_ctl.letter;
                res.command_number = rec_acc[15:0];
                res.has_digits     = rec_ctl.digit_seen;
                res.saturated      = rec_ctl.overflow;
            end
            KIND_PARAM:
            begin
                res.letter      = rec_ctl.letter;
                res.value_milli = signed'(val_full[31:0]);
                res.saturated   = sat;
            end
            default:
            begin
                res.kind = KIND_LINE_END;
            end
        endcase
    end

    assign rec_ready = (count_reg != LVL_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign result    = entry_reg[rd_ptr_reg];
    assign do_push   = rec_valid && rec_ready;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + LVL_W'(do_push) - LVL_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ----- src/gcode_word_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gcode_word_tokenizer_core
// G-code text tokenizer: characters in, command and parameter words out.
// ============================================================================
// Characters are pushed one per cycle while full is low; the block sustains
// one character per clock unless the result queue is full, a figure set by the
// scanner, which folds each character into the current word (a multiply-by-ten
// accumulate) as it takes it. A word ending on a character passes from the
// character queue through the scanner's word register into the result queue,
// with scaling to thousandths and clamping done on the way in. The character
// queue holds two characters and the result queue two words, so either side
// may stall without stopping the other until its queue fills. Words carry the
// kind, the upper-case letter, the command number or the signed value in
// thousandths, a saturation flag, and line_end on the last word of a line.
// There is no clearing pass after reset.
module gcode_word_tokenizer_core #(
    parameter int VALUE_BITS      = 32,
    parameter int FRACTION_DIGITS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         char_byte,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         word_kind,
    output logic [6:0]         word_letter,
    output logic [15:0]        command_number,
    output logic               command_has_digits,
    output logic signed [31:0] value_milli,
    output logic               saturated,
    output logic               line_end
);
    import gwt_pkg::*;

    localparam int FRAC_W = frac_bits(FRACTION_DIGITS);

    logic                   deq_valid;
    logic                   deq_ready;
    char_class_t            deq_class;
    logic                   rec_valid;
    logic                   rec_ready;
    word_ctl_t              rec_ctl;
    logic [VALUE_BITS-1:0]  rec_acc;
    logic [FRAC_W-1:0]      rec_frac;
    result_t                result;

    gwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_byte (char_byte),
        .full      (full),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_class (deq_class)
    );

    gwt_scanner #(
        .VALUE_BITS      (VALUE_BITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (deq_valid),
        .in_class  (deq_class),
        .in_ready  (deq_ready),
        .rec_valid (rec_valid),
        .rec_ctl   (rec_ctl),
        .rec_acc   (rec_acc),
        .rec_frac  (rec_frac),
        .rec_ready (rec_ready)
    );

    gwt_formatter #(
        .VALUE_BITS      (VALUE_BITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_formatter (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ctl   (rec_ctl),
        .rec_acc   (rec_acc),
        .rec_frac  (rec_frac),
        .rec_ready (rec_ready),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign word_kind          = result.kind;
    assign word_letter        = result.letter;
    assign command_number     = result.command_number;
    assign command_has_digits = result.has_digits;
    assign value_milli        = result.value_milli;
    assign saturated          = result.saturated;
    assign line_end           = result.line_end;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the G-code word tokenizer core.
// ============================================================================
// Text is pushed one character at a time: a few hand-written lines that hit
// the corner cases, then randomly built G-code lines mixed with noise and
// broken lines. A software tokenizer inside the scoreboard predicts every
// word, and each popped word is compared field by field with the oldest
// prediction. Sender gaps and receiver stalls vary by phase. One phase holds
// the receiver off long enough for the block to fill and push back.
module testbench;

    import gwt_pkg::*;

    localparam int          FRAC_DIGITS    = 3;
    localparam logic [63:0] MILLI_SCALE    = 64'd1000;
    localparam logic [63:0] POS_LIMIT      = 64'h7FFF_FFFF;
    localparam logic [63:0] INT_CAP        = 64'h8000_0000;
    localparam logic [7:0]  LOWER_CASE_BIT = 8'h20;
    localparam int          PHASE_CHARS    = 90;
    localparam int          PRESSURE_CHARS = 60;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_REPORTS    = 100;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic [7:0]         char_byte;
    logic               full;
    logic               empty;
    logic               pop;
    logic [1:0]         word_kind;
    logic [6:0]         word_letter;
    logic [15:0]        command_number;
    logic               command_has_digits;
    logic signed [31:0] value_milli;
    logic               saturated;
    logic               line_end;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit start_hold     = 1'b0;
    bit hold_taken     = 1'b0;

    logic [7:0] line_chars[$];

    gcode_word_tokenizer_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .char_byte         (char_byte),
        .full              (full),
        .empty             (empty),
        .pop               (pop),
        .word_kind         (word_kind),
        .word_letter       (word_letter),
        .command_number    (command_number),
        .command_has_digits(command_has_digits),
        .value_milli       (value_milli),
        .saturated         (saturated),
        .line_end          (line_end)
    );

    always #5 clk = ~clk;

    class word_scoreboard;
        result_t     expected_words[$];
        int unsigned mismatches;

        phase_t      phase;
        logic [6:0]  letter;
        bit          negative;
        bit          digit_seen;
        bit          dot_seen;
        bit          overflow;
        logic [63:0] int_acc;
        logic [31:0] frac_acc;
        int          frac_cnt;

        function new();
            mismatches = 0;
            phase      = PH_LINE_START;
            letter     = '0;
            clear_number();
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z);
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void clear_number();
            negative   = 1'b0;
            digit_seen = 1'b0;
            dot_seen   = 1'b0;
            overflow   = 1'b0;
            int_acc    = '0;
            frac_acc   = '0;
            frac_cnt   = 0;
        endfunction

        // Scale to thousandths and clamp; a negative value may reach one
        // step further than a positive one.
        function result_t param_word();
            result_t     w;
            logic [63:0] limit;
            logic [63:0] frac;
            logic [63:0] mag;
            bit          sat;
            limit = POS_LIMIT + (negative ? 64'd1 : 64'd0);
            frac  = 64'(frac_acc);
            for (int i = frac_cnt; i < FRAC_DIGITS; i++)
            begin
                frac = frac * 10;
            end
            sat = overflow;
            if (!sat && (frac > limit || int_acc > (limit - frac) / MILLI_SCALE))
            begin
                sat = 1'b1;
            end
            mag = sat ? limit : int_acc * MILLI_SCALE + frac;
            w             = '0;
            w.kind        = KIND_PARAM;
            w.letter      = letter;
            w.value_milli = negative ? -mag[31:0] : mag[31:0];
            w.saturated   = sat;
            return w;
        endfunction

        function bit close_word(output result_t w);
            bit produced;
            produced = 1'b0;
            w        = '0;
            if (phase == PH_COMMAND)
            begin
                w.kind           = KIND_COMMAND;
                w.letter         = letter;
                w.command_number = int_acc[15:0];
                w.has_digits     = digit_seen;
                w.saturated      = overflow;
                produced         = 1'b1;
            end
            else if ((phase == PH_NUMBER || phase == PH_TAIL) && digit_seen)
            begin
                w        = param_word();
                produced = 1'b1;
            end
            phase = PH_SCAN;
            clear_number();
            return produced;
        endfunction

        function void scan_char(logic [7:0] c);
            if (is_alpha(c))
            begin
                letter = c[6:0] & CASE_MASK;
                clear_number();
                phase = PH_SIGN;
            end
            else if (c == CH_SEMI)
            begin
                phase = PH_COMMENT;
            end
            else
            begin
                phase = PH_SCAN;
            end
        endfunction

        function void number_char(logic [7:0] c);
            logic [63:0] d;
            d = 64'(c) - 64'(CH_ZERO);
            if (c == CH_DOT)
            begin
                // A second dot ends the value; the rest of the run is eaten.
                if (dot_seen)
                    phase = PH_TAIL;
                else
                    dot_seen = 1'b1;
            end
            else
            begin
                digit_seen = 1'b1;
                if (dot_seen)
                begin
                    if (frac_cnt < FRAC_DIGITS)
                    begin
                        frac_acc = frac_acc * 10 + d[31:0];
                        frac_cnt++;
                    end
                end
                else if (int_acc > (INT_CAP - d) / 10)
                begin
                    int_acc  = INT_CAP;
                    overflow = 1'b1;
                end
                else
                begin
                    int_acc = int_acc * 10 + d;
                end
            end
        endfunction

        function void note_char(logic [7:0] c);
            result_t w;
            bit      closing;
            closing = 1'b0;
            if (c == CH_NEWLINE)
            begin
                if (!close_word(w))
                begin
                    w      = '0;
                    w.kind = KIND_LINE_END;
                end
                w.line_end = 1'b1;
                expected_words.push_back(w);
                phase  = PH_LINE_START;
                letter = '0;
                clear_number();
            end
            else
            begin
                case (phase)
                    PH_LINE_START:
                    begin
                        if (is_alpha(c))
                        begin
                            letter = c[6:0] & CASE_MASK;
                            clear_number();
                            phase = PH_COMMAND;
                        end
                        else if (!is_blank(c))
                        begin
                            scan_char(c);
                        end
                    end
                    PH_COMMAND:
                    begin
                        if (is_num(c))
                        begin
                            digit_seen = 1'b1;
                            int_acc    = int_acc * 10 + 64'(c - CH_ZERO);
                            if (int_acc > 64'(CMD_MAX))
                            begin
                                int_acc  = 64'(CMD_MAX);
                                overflow = 1'b1;
                            end
                        end
                        else
                        begin
                            closing = 1'b1;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (c == CH_PLUS || c == CH_MINUS)
                        begin
                            negative = (c == CH_MINUS);
                            phase    = PH_NUMBER;
                        end
                        else if (is_num(c) || c == CH_DOT)
                        begin
                            phase = PH_NUMBER;
                            number_char(c);
                        end
                        else
                        begin
                            closing = 1'b1;
                        end
                    end
                    PH_NUMBER:
                    begin
                        if (is_num(c) || c == CH_DOT)
                            number_char(c);
                        else
                            closing = 1'b1;
                    end
                    PH_TAIL:
                    begin
                        if (!(is_num(c) || c == CH_DOT))
                            closing = 1'b1;
                    end
                    PH_COMMENT:
                    begin
                    end
                    default:
                    begin
                        scan_char(c);
                    end
                endcase
                if (closing)
                begin
                    if (close_word(w))
                        expected_words.push_back(w);
                    scan_char(c);
                end
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("word popped with none expected: kind %0d letter 'h%0h",
                           got.kind, got.letter);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind)
                    report("word_kind", want.kind, got.kind);
                if (got.letter !== want.letter)
                    report("word_letter", want.letter, got.letter);
                if (got.command_number !== want.command_number)
                    report("command_number", want.command_number, got.command_number);
                if (got.has_digits !== want.has_digits)
                    report("command_has_digits", want.has_digits, got.has_digits);
                if (got.value_milli !== want.value_milli)
                    report("value_milli", want.value_milli, got.value_milli);
                if (got.saturated !== want.saturated)
                    report("saturated", want.saturated, got.saturated);
                if (got.line_end !== want.line_end)
                    report("line_end", want.line_end, got.line_end);
            end
        endfunction
    endclass

    word_scoreboard sb = new();

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_byte <= c;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        sb.note_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    task automatic send_line();
        foreach (line_chars[i])
        begin
            send_char(line_chars[i]);
        end
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = CH_UP_A + 8'($urandom_range(25));
        if ($urandom_range(1))
            c = c | LOWER_CASE_BIT;
        return c;
    endfunction

    function automatic void add_digits(input int n);
        repeat (n)
        begin
            line_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endfunction

    // Mostly well-formed lines with random content; the rest are byte noise.
    function automatic void build_line();
        logic [7:0] c;
        int         sign_sel;
        line_chars.delete();
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(12))
            begin
                c = 8'($urandom_range(255));
                if (c != CH_NEWLINE)
                    line_chars.push_back(c);
            end
        end
        else
        begin
            repeat ($urandom_range(2))
            begin
                line_chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            end
            if ($urandom_range(9) != 0)
            begin
                line_chars.push_back(rand_letter());
                add_digits(($urandom_range(9) == 0) ? $urandom_range(5, 7)
                                                    : $urandom_range(0, 3));
            end
            repeat ($urandom_range(4))
            begin
                if ($urandom_range(1))
                    line_chars.push_back(CH_SPACE);
                line_chars.push_back(rand_letter());
                sign_sel = $urandom_range(9);
                if (sign_sel < 3)
                    line_chars.push_back(CH_MINUS);
                else if (sign_sel < 5)
                    line_chars.push_back(CH_PLUS);
                if (sign_sel == 0 && $urandom_range(3) == 0)
                    line_chars.push_back(CH_MINUS);
                add_digits(($urandom_range(7) == 0) ? $urandom_range(7, 12)
                                                    : $urandom_range(0, 4));
                if ($urandom_range(1))
                begin
                    line_chars.push_back(CH_DOT);
                    add_digits($urandom_range(5));
                    if ($urandom_range(5) == 0)
                    begin
                        line_chars.push_back(CH_DOT);
                        add_digits($urandom_range(2));
                    end
                end
            end
            if ($urandom_range(7) == 0)
            begin
                line_chars.push_back(CH_SEMI);
                repeat ($urandom_range(4))
                begin
                    line_chars.push_back(8'($urandom_range(32, 126)));
                end
            end
        end
        line_chars.push_back(CH_NEWLINE);
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int chars);
        int sent;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < chars)
        begin
            build_line();
            send_line();
            sent += line_chars.size();
        end
    endtask

    // Result side: check each popped word, then decide the next pop.
    initial
    begin
        result_t got;
        int      hold_left;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.kind           = word_kind_t'(word_kind);
                got.letter         = word_letter;
                got.command_number = command_number;
                got.has_digits     = command_has_digits;
                got.value_milli    = value_milli;
                got.saturated      = saturated;
                got.line_end       = line_end;
                sb.check_word(got);
            end
            if (start_hold && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (!rst_n)
            begin
                pop <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run when no character is taken and no word is popped for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        push      <= 1'b0;
        char_byte <= '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty line, blank-and-comment line, lower-case command ending the
        // line, and a command letter without digits.
        send_text("\n \t;x\ng0\nM\n");
        // Saturated command, most negative value, largest positive value
        // with an excess fraction digit truncated.
        send_text("G99999X-2147483.648Y2147483.6479\n");
        // Second dot, lone sign, dots only, bare fraction, double sign and
        // an integer part too large for the field.
        send_text("G1 x+1.2.3 Y- Z. E.5 A--1 F99999999999\n");
        // Line not starting with a letter, digits after the command word,
        // a dropped word, a byte outside ASCII and a NUL byte.
        send_text("5 A7\nG1.5A");
        send_char(8'hFF);
        send_char(8'h00);
        send_text("Z1\n");

        run_phase(0, 0, PHASE_CHARS);
        run_phase(83, 0, PHASE_CHARS);
        run_phase(0, 83, PHASE_CHARS);
        run_phase(26, 26, PHASE_CHARS);

        // Receiver holds off while the sender keeps pushing.
        start_hold = 1'b1;
        run_phase(0, 0, PRESSURE_CHARS);

        push <= 1'b0;
        while (sb.expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/gwt_pkg.sv
src/gwt_front.sv
src/gwt_scanner.sv
src/gwt_formatter.sv
src/gcode_word_tokenizer_core.sv
sim/testbench.sv
